### rtl/core/etb_pkg.sv
// shared types and constants for the elimination tree builder
`default_nettype none

package etb_pkg;

  localparam int FIELD_W       = 10;
  localparam int MAX_NODES_DEF = 1024;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DATA_W        = 24;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_ENTRY = 1'b1
  } req_kind_t;

  // one queued command: either a clear of the ancestor store or a walk
  typedef struct packed {
    logic               clear;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP
  } back_state_t;

  // one memory word: valid flag above the ancestor link
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] link;
  } anc_word_t;

endpackage

`default_nettype wire

### rtl/core/etb_front.sv
// front end: accepts requests, drops ignored entries, queues commands
`default_nettype none

module etb_front #(
  parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic                       req_type,
  input  wire logic [etb_pkg::FIELD_W-1:0] column,
  input  wire logic [etb_pkg::FIELD_W-1:0] row,
  input  wire etb_pkg::back_status_t      status,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output etb_pkg::cmd_t                   cmd
);

  localparam int QD  = etb_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  etb_pkg::cmd_t queue [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;

  logic full;
  logic is_start;
  logic in_range;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    full      = (count == (QAW+1)'(QD));
    is_start  = (etb_pkg::req_kind_t'(req_type) == etb_pkg::REQ_START);
    in_range  = (32'(column) < MAX_NODES) && (32'(row) < MAX_NODES);
    keep      = is_start || (in_range && (row < column));
    s_tready  = !full && !status.clearing;
    push      = s_tvalid && s_tready && keep;
    cmd_valid = (count != '0);
    pop       = cmd_valid && cmd_ready;
    cmd       = queue[rd_ptr];
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].clear  <= is_start;
      queue[wr_ptr].column <= column;
      queue[wr_ptr].row    <= row;
    end
  end

endmodule

`default_nettype wire

### rtl/core/etb_back.sv
// back end: ancestor store, clearing sweep, path-compressed walk, result register
`default_nettype none

module etb_back #(
  parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire etb_pkg::cmd_t               cmd,
  output etb_pkg::back_status_t            status,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [etb_pkg::FIELD_W-1:0]      child,
  output logic [etb_pkg::FIELD_W-1:0]      parent_node
);

  localparam int AW = $clog2(MAX_NODES);

  etb_pkg::anc_word_t mem [MAX_NODES];
  etb_pkg::anc_word_t rdata;
  etb_pkg::anc_word_t wdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [AW-1:0]      raddr;

  etb_pkg::back_state_t state;
  etb_pkg::back_state_t state_next;
  logic [AW-1:0]               clr_addr;
  logic [AW-1:0]               clr_addr_next;
  logic [etb_pkg::FIELD_W-1:0] col_r;
  logic [etb_pkg::FIELD_W-1:0] col_r_next;
  logic [etb_pkg::FIELD_W-1:0] node_r;
  logic [etb_pkg::FIELD_W-1:0] node_r_next;
  logic                        out_load;
  logic                        out_free;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    col_r_next    = col_r;
    node_r_next   = node_r;
    cmd_ready     = 1'b0;
    we            = 1'b0;
    waddr         = AW'(node_r);
    wdata.valid   = 1'b1;
    wdata.link    = col_r;
    re            = 1'b0;
    raddr         = AW'(rdata.link);
    out_load      = 1'b0;
    out_free      = !m_tvalid || m_tready;
    status.clearing = (state == etb_pkg::ST_CLEAR);
    unique case (state)
      etb_pkg::ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_addr;
        wdata.valid = 1'b0;
        if (clr_addr == AW'(MAX_NODES - 1)) begin
          state_next = etb_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      etb_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.clear) begin
            clr_addr_next = '0;
            state_next    = etb_pkg::ST_CLEAR;
          end else begin
            col_r_next  = cmd.column;
            node_r_next = cmd.row;
            re          = 1'b1;
            raddr       = AW'(cmd.row);
            state_next  = etb_pkg::ST_STEP;
          end
        end
      end
      etb_pkg::ST_STEP: begin
        if (!rdata.valid) begin
          // root of the walk reached: it takes the column as parent
          if (out_free) begin
            we         = 1'b1;
            out_load   = 1'b1;
            state_next = etb_pkg::ST_IDLE;
          end
        end else begin
          we = 1'b1;
          if (rdata.link < col_r) begin
            node_r_next = rdata.link;
            re          = 1'b1;
          end else begin
            state_next = etb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = etb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= etb_pkg::ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_r_next;
    node_r <= node_r_next;
    if (out_load) begin
      child       <= node_r;
      parent_node <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/elimination_tree_builder_top.sv
// top level of the elimination tree builder
//
// requests enter on the s_ channel: tuser is the kind (0 starts a new
// matrix and clears all ancestors, 1 is a nonzero entry), tdata carries
// column and row. entries with row at or above column, or an index at or
// beyond MAX_NODES, are dropped at the front. each walk request yields at
// most one result on the m_ channel: a child node and its parent (the
// entry's column). a request is queued in the front end; the back end then
// reads the row's ancestor to start the walk and follows ancestor links
// through the one-read one-write ancestor memory, so the time an entry
// takes follows the compressed path length; it takes no new command until
// the walk is done. a start request and reset each sweep the ancestor
// memory, one entry per cycle; s_tready is low during the sweep. when the
// receiver stalls, the result waits in the output register, a walk at its
// root holds, and the command queue keeps taking requests until it is full.
`default_nettype none

module elimination_tree_builder_top #(
  parameter int MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [etb_pkg::DATA_W-1:0]  s_tdata,   // column, row, zero pad
  input  wire logic                        s_tuser,   // req_type
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [etb_pkg::DATA_W-1:0]       m_tdata    // child, parent_node, zero pad
);

  localparam int FW = etb_pkg::FIELD_W;

  etb_pkg::cmd_t         cmd;
  logic                  cmd_valid;
  logic                  cmd_ready;
  etb_pkg::back_status_t status;
  logic [FW-1:0]         child;
  logic [FW-1:0]         parent_node;

  etb_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .req_type  (s_tuser),
    .column    (s_tdata[FW-1:0]),
    .row       (s_tdata[2*FW-1:FW]),
    .status    (status),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  etb_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .child       (child),
    .parent_node (parent_node)
  );

  assign m_tdata = {(etb_pkg::DATA_W - 2*FW)'(0), parent_node, child};

endmodule

`default_nettype wire
